/* sv/cfuv_pkg.sv */
// Package: widths, face codes and item types for cube face selection.
package cfuv_pkg;

  localparam int COMP_BITS    = 16;
  localparam int UV_FRAC_BITS = 16;

  // remainder / divisor width and quotient width of the divider chain
  localparam int RW = COMP_BITS + 1;
  localparam int QW = UV_FRAC_BITS + 1;

  // two front stages then one cell per quotient bit
  localparam int FRONT_STAGES = 2;
  localparam int LATENCY      = FRONT_STAGES + QW;

  localparam logic [QW-1:0] COORD_ONE = QW'(1) << UV_FRAC_BITS;

  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] dir_x;
    logic signed [COMP_BITS-1:0] dir_y;
    logic signed [COMP_BITS-1:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0]    face;
    logic [QW-1:0] coord_u;
    logic [QW-1:0] coord_v;
    logic          degenerate;
  } out_item_t;

  typedef struct packed {
    logic          valid;
    logic [2:0]    face;
    logic          degenerate;
    logic [RW-1:0] divisor;
    logic [RW-1:0] rem_u;
    logic [RW-1:0] rem_v;
    logic [QW-1:0] quo_u;
    logic [QW-1:0] quo_v;
  } lane_t;

endpackage

/* sv/cube_face_uv_select.sv */
// Top level: cube map face selection with face coordinates u and v.
//
// Usage:
//   Drive in_data with a direction (three signed Q1.15 components) and raise
//   start. The item is taken at a rising edge with start high and busy low;
//   busy stays low, so a new item may be offered in every cycle.
//   Each item yields one result on out_data, marked by out_valid for exactly
//   one cycle, in the order the items were taken.
//   From the accepting edge an item passes two front stages (major
//   axis, face, dividends) then a chain of 17 divider cells, one quotient bit
//   of u and of v per cell. Throughput is one item per cycle.
//   A zero vector gives face -Z, u = v = 0 and degenerate set.
//   Synchronous active-low reset empties the chain; items in flight are lost
//   and no result appears until new items arrive.
//   The receiver cannot stall the block: a result not taken in its cycle is
//   gone.
module cube_face_uv_select (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cfuv_pkg::in_item_t  in_data,
  output logic                out_valid,
  output cfuv_pkg::out_item_t out_data
);

  localparam int QW = cfuv_pkg::QW;

  cfuv_pkg::lane_t lane [0:QW];

  assign busy = 1'b0;

  cfuv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (start && !busy),
    .in_data  (in_data),
    .lane_out (lane[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    cfuv_cell #(
      .DOUBLE ((i == 0) ? 1'b0 : 1'b1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .lane_in  (lane[i]),
      .lane_out (lane[i+1])
    );
  end

  assign out_valid           = lane[QW].valid;
  assign out_data.face       = lane[QW].face;
  assign out_data.coord_u    = lane[QW].quo_u;
  assign out_data.coord_v    = lane[QW].quo_v;
  assign out_data.degenerate = lane[QW].degenerate;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(cfuv_pkg::LATENCY) out_valid)
    else $error("item taken but no result after the pipeline latency");

  a_coord_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.coord_u <= cfuv_pkg::COORD_ONE) &&
                  (out_data.coord_v <= cfuv_pkg::COORD_ONE))
    else $error("face coordinate above one");

  a_degenerate : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |->
      (out_data.face == cfuv_pkg::FACE_NEG_Z) &&
      (out_data.coord_u == '0) && (out_data.coord_v == '0))
    else $error("zero vector result not on -Z with zero coordinates");

endmodule

/* sv/cfuv_front.sv */
// Front stages: component magnitudes, major axis and face, dividends and divisor.
module cfuv_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  cfuv_pkg::in_item_t in_data,
  output cfuv_pkg::lane_t   lane_out
);

  localparam int C  = cfuv_pkg::COMP_BITS;
  localparam int RW = cfuv_pkg::RW;

  logic                valid1_r;
  logic signed [C-1:0] x_r, y_r, z_r;
  logic [C-1:0]        ax_r, ay_r, az_r;
  logic [C-1:0]        ax_nxt, ay_nxt, az_nxt;

  always_comb begin
    ax_nxt = in_data.dir_x[C-1] ? (~in_data.dir_x + 1'b1) : in_data.dir_x;
    ay_nxt = in_data.dir_y[C-1] ? (~in_data.dir_y + 1'b1) : in_data.dir_y;
    az_nxt = in_data.dir_z[C-1] ? (~in_data.dir_z + 1'b1) : in_data.dir_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else begin
      valid1_r <= in_take;
    end
    x_r  <= in_data.dir_x;
    y_r  <= in_data.dir_y;
    z_r  <= in_data.dir_z;
    ax_r <= ax_nxt;
    ay_r <= ay_nxt;
    az_r <= az_nxt;
  end

  logic              ymax, zmax;
  logic [C:0]        xe, ye, ze;
  logic [C:0]        uc, vc;
  logic [C-1:0]      m;
  logic [2:0]        face_nxt;
  cfuv_pkg::lane_t   lane_nxt;
  cfuv_pkg::lane_t   lane_r;

  always_comb begin
    xe   = {x_r[C-1], x_r};
    ye   = {y_r[C-1], y_r};
    ze   = {z_r[C-1], z_r};
    ymax = (ay_r >= ax_r) && (ay_r >= az_r);
    zmax = (az_r >= ax_r) && (az_r >= ay_r);
    priority if (zmax) begin
      m  = az_r;
      vc = ye;
      if (!z_r[C-1] && (z_r != '0)) begin
        uc = xe;
        face_nxt = cfuv_pkg::FACE_POS_Z;
      end else begin
        uc = ~xe + 1'b1;
        face_nxt = cfuv_pkg::FACE_NEG_Z;
      end
    end else if (ymax) begin
      m  = ay_r;
      uc = xe;
      if (!y_r[C-1] && (y_r != '0)) begin
        vc = ~ze + 1'b1;
        face_nxt = cfuv_pkg::FACE_POS_Y;
      end else begin
        vc = ze;
        face_nxt = cfuv_pkg::FACE_NEG_Y;
      end
    end else begin
      m  = ax_r;
      vc = ye;
      if (!x_r[C-1] && (x_r != '0)) begin
        uc = ~ze + 1'b1;
        face_nxt = cfuv_pkg::FACE_POS_X;
      end else begin
        uc = ze;
        face_nxt = cfuv_pkg::FACE_NEG_X;
      end
    end

    lane_nxt.valid      = valid1_r;
    lane_nxt.face       = face_nxt;
    lane_nxt.degenerate = (m == '0);
    // a zero vector divides 0 by 1, giving zero coordinates
    lane_nxt.divisor    = (m == '0) ? RW'(1) : {m, 1'b0};
    lane_nxt.rem_u      = uc + {1'b0, m};
    lane_nxt.rem_v      = vc + {1'b0, m};
    lane_nxt.quo_u      = '0;
    lane_nxt.quo_v      = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else begin
      lane_r.valid <= lane_nxt.valid;
    end
    lane_r.face       <= lane_nxt.face;
    lane_r.degenerate <= lane_nxt.degenerate;
    lane_r.divisor    <= lane_nxt.divisor;
    lane_r.rem_u      <= lane_nxt.rem_u;
    lane_r.rem_v      <= lane_nxt.rem_v;
    lane_r.quo_u      <= lane_nxt.quo_u;
    lane_r.quo_v      <= lane_nxt.quo_v;
  end

  assign lane_out = lane_r;

endmodule

/* sv/cfuv_cell.sv */
// Divider cell: one quotient bit for u and for v, handed on to the next cell.
module cfuv_cell #(
  parameter bit DOUBLE = 1'b1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cfuv_pkg::lane_t lane_in,
  output cfuv_pkg::lane_t lane_out
);

  localparam int RW = cfuv_pkg::RW;
  localparam int QW = cfuv_pkg::QW;

  logic [RW-1:0]   ru, rv;
  logic            ge_u, ge_v;
  cfuv_pkg::lane_t lane_nxt;
  cfuv_pkg::lane_t lane_r;

  always_comb begin
    ru   = DOUBLE ? {lane_in.rem_u[RW-2:0], 1'b0} : lane_in.rem_u;
    rv   = DOUBLE ? {lane_in.rem_v[RW-2:0], 1'b0} : lane_in.rem_v;
    ge_u = (ru >= lane_in.divisor);
    ge_v = (rv >= lane_in.divisor);
    lane_nxt       = lane_in;
    lane_nxt.rem_u = ge_u ? (ru - lane_in.divisor) : ru;
    lane_nxt.rem_v = ge_v ? (rv - lane_in.divisor) : rv;
    lane_nxt.quo_u = {lane_in.quo_u[QW-2:0], ge_u};
    lane_nxt.quo_v = {lane_in.quo_v[QW-2:0], ge_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else begin
      lane_r.valid <= lane_nxt.valid;
    end
    lane_r.face       <= lane_nxt.face;
    lane_r.degenerate <= lane_nxt.degenerate;
    lane_r.divisor    <= lane_nxt.divisor;
    lane_r.rem_u      <= lane_nxt.rem_u;
    lane_r.rem_v      <= lane_nxt.rem_v;
    lane_r.quo_u      <= lane_nxt.quo_u;
    lane_r.quo_v      <= lane_nxt.quo_v;
  end

  assign lane_out = lane_r;

endmodule
